@@ src/vector_reflection_2d_core_defines.svh @@
// Assertion macros shared by the vector reflection core modules.
`ifndef VECTOR_REFLECTION_2D_CORE_DEFINES_SVH
`define VECTOR_REFLECTION_2D_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/vrf_pkg.sv @@
// Types and constants of the vector reflection core.
package vrf_pkg;

  localparam int DATA_W     = 16;                      // Q8.8 component
  localparam int PROD_W     = 2 * DATA_W;              // 16x16 product
  localparam int DOT_W      = PROD_W + 1;              // u.n, signed
  localparam int MAG_W      = PROD_W;                  // n.n and |u.n|, unsigned
  localparam int FRAC_SH    = 9;                       // times 2 times 256
  localparam int NUM_W      = MAG_W + FRAC_SH;         // dividend bits
  localparam int DIV_STEPS  = NUM_W;                   // one quotient bit per stage
  localparam int QUO_W      = 27;                      // quotient bits that reach the result
  localparam int Q_SH       = 8;                       // Q.8 back to integer
  localparam int SUM_W      = QUO_W - Q_SH + 1;        // u - shifted product
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Per-beat data that rides alongside the arithmetic.
  typedef struct packed {
    data_t ux;
    data_t uy;
    data_t nx;
    data_t ny;
    logic  zero;
    logic  neg;
  } side_t;

  typedef struct packed {
    data_t rx;
    data_t ry;
    logic  saturated;
    logic  zero_normal;
  } res_t;

endpackage

@@ src/vrf_if.sv @@
// Valid/ready channel interfaces of the vector reflection core.
interface vrf_in_if;
  import vrf_pkg::*;

  logic  valid;
  logic  ready;
  data_t ux;
  data_t uy;
  data_t nx;
  data_t ny;

  modport source (output valid, output ux, output uy, output nx, output ny, input ready);
  modport sink   (input valid, input ux, input uy, input nx, input ny, output ready);
endinterface

interface vrf_out_if;
  import vrf_pkg::*;

  logic  valid;
  logic  ready;
  data_t rx;
  data_t ry;
  logic  saturated;
  logic  zero_normal;

  modport source (output valid, output rx, output ry, output saturated, output zero_normal,
                  input ready);
  modport sink   (input valid, input rx, input ry, input saturated, input zero_normal,
                  output ready);
endinterface

@@ src/vrf_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`include "vector_reflection_2d_core_defines.svh"

module vrf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [vrf_pkg::NUM_W-1:0]  in_num,
  input  logic [vrf_pkg::MAG_W-1:0]  in_den,
  input  vrf_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [vrf_pkg::QUO_W-1:0]  out_quo,
  output vrf_pkg::side_t             out_side
);
  import vrf_pkg::*;

  logic [DIV_STEPS:1] v_r;
  logic [MAG_W-1:0]   rem_r  [1:DIV_STEPS];
  logic [NUM_W-1:0]   num_r  [1:DIV_STEPS];
  logic [QUO_W-1:0]   quo_r  [1:DIV_STEPS];
  logic [MAG_W-1:0]   den_r  [1:DIV_STEPS];
  side_t              side_r [1:DIV_STEPS];

  genvar s;
  generate
    for (s = 0; s < DIV_STEPS; s++) begin : g_step
      logic             cur_v;
      logic [MAG_W-1:0] cur_rem;
      logic [NUM_W-1:0] cur_num;
      logic [QUO_W-1:0] cur_quo;
      logic [MAG_W-1:0] cur_den;
      side_t            cur_side;
      logic [MAG_W:0]   trial;
      logic [MAG_W:0]   diff;
      logic             ge;

      if (s == 0) begin : g_first
        assign cur_v    = in_valid;
        assign cur_rem  = '0;
        assign cur_num  = in_num;
        assign cur_quo  = '0;
        assign cur_den  = in_den;
        assign cur_side = in_side;
      end else begin : g_rest
        assign cur_v    = v_r[s];
        assign cur_rem  = rem_r[s];
        assign cur_num  = num_r[s];
        assign cur_quo  = quo_r[s];
        assign cur_den  = den_r[s];
        assign cur_side = side_r[s];
      end

      assign trial = {cur_rem, cur_num[NUM_W-1]};
      assign diff  = trial - {1'b0, cur_den};
      assign ge    = (trial >= {1'b0, cur_den});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s+1] <= 1'b0;
        end else if (en) begin
          v_r[s+1] <= cur_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1]  <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          num_r[s+1]  <= {cur_num[NUM_W-2:0], 1'b0};
          quo_r[s+1]  <= {cur_quo[QUO_W-2:0], ge};
          den_r[s+1]  <= cur_den;
          side_r[s+1] <= cur_side;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[DIV_STEPS];
  assign out_quo   = quo_r[DIV_STEPS];
  assign out_side  = side_r[DIV_STEPS];

  `VRF_ASSERT_NOW(a_rem_below_den, v_r[DIV_STEPS] && den_r[DIV_STEPS] != '0, rem_r[DIV_STEPS] < den_r[DIV_STEPS], "divider remainder not below divisor")
  `VRF_ASSERT_NEXT(a_last_moves, en && v_r[DIV_STEPS-1], v_r[DIV_STEPS], "divider beat lost at last stage")
  `VRF_ASSERT_NEXT(a_stall_holds, !en, $stable(quo_r[DIV_STEPS]) && $stable(v_r), "divider moved while stalled")

endmodule

@@ src/vector_reflection_2d_core.sv @@
// Top level: reflection of a 2D vector about a normal, fully pipelined.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  in_ch    | in  | valid/ready        | ux, uy, nx, ny (signed Q8.8)
//  out_ch   | out | valid/ready        | rx, ry (signed Q8.8), saturated,
//           |     |                    | zero_normal
//
// One beat per cycle while the output FIFO has room; 3 product/sum stages,
// 41 divider stages of one quotient bit each, 2 scale stages, output FIFO.
// The 41-stage divider of (2*256*u.n) by n.n sets the depth.
// rst_n is synchronous and clears the valid bits and the FIFO count.
// The pipeline stalls as a whole only while the 2-entry output FIFO is full;
// in_ch.ready comes from a register, not from out_ch.ready.
`include "vector_reflection_2d_core_defines.svh"

module vector_reflection_2d_core (
  input  logic      clk,
  input  logic      rst_n,
  vrf_in_if.sink    in_ch,
  vrf_out_if.source out_ch
);
  import vrf_pkg::*;

  logic en_w;
  logic push_w;
  logic pop_w;

  // stage 1: products
  logic                     v1_r;
  logic signed [PROD_W-1:0] p_ux_r;
  logic signed [PROD_W-1:0] p_uy_r;
  logic signed [PROD_W-1:0] p_nx_r;
  logic signed [PROD_W-1:0] p_ny_r;
  side_t                    side1_r;

  // stage 2: dot and squared length
  logic                    v2_r;
  logic signed [DOT_W-1:0] dot_r;
  logic [MAG_W-1:0]        mag2_r;
  side_t                   side2_r;

  // stage 3: magnitude and sign
  logic             v3_r;
  logic [MAG_W-1:0] abs_r;
  logic [MAG_W-1:0] mag3_r;
  side_t            side3_r;

  // divider output
  logic             vd_w;
  logic [QUO_W-1:0] quo_w;
  side_t            sided_w;

  // stage 4: signed quotient
  logic                    v4_r;
  logic signed [QUO_W-1:0] q_r;
  side_t                   side4_r;

  // stage 5: scaled normal
  logic                           v5_r;
  logic signed [QUO_W+DATA_W-1:0] full_x_w;
  logic signed [QUO_W+DATA_W-1:0] full_y_w;
  logic signed [QUO_W-1:0]        px_r;
  logic signed [QUO_W-1:0]        py_r;
  side_t                          side5_r;

  // result
  logic signed [SUM_W-1:0] sx_w;
  logic signed [SUM_W-1:0] sy_w;
  logic signed [SUM_W-1:0] dx_w;
  logic signed [SUM_W-1:0] dy_w;
  logic                    ovx_w;
  logic                    ovy_w;
  res_t                    res_w;

  // output FIFO
  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign en_w        = (cnt_r != CNT_W'(FIFO_DEPTH));
  assign in_ch.ready = en_w;

  // ---- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en_w) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_w) begin
      p_ux_r  <= PROD_W'(in_ch.ux) * PROD_W'(in_ch.nx);
      p_uy_r  <= PROD_W'(in_ch.uy) * PROD_W'(in_ch.ny);
      p_nx_r  <= PROD_W'(in_ch.nx) * PROD_W'(in_ch.nx);
      p_ny_r  <= PROD_W'(in_ch.ny) * PROD_W'(in_ch.ny);
      side1_r <= '{ux: in_ch.ux, uy: in_ch.uy, nx: in_ch.nx, ny: in_ch.ny,
                   zero: 1'b0, neg: 1'b0};
    end
  end

  // ---- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en_w) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_w) begin
      dot_r   <= DOT_W'(p_ux_r) + DOT_W'(p_uy_r);
      mag2_r  <= MAG_W'($unsigned(p_nx_r)) + MAG_W'($unsigned(p_ny_r));
      side2_r <= '{ux: side1_r.ux, uy: side1_r.uy, nx: side1_r.nx, ny: side1_r.ny,
                   zero: (side1_r.nx == '0) && (side1_r.ny == '0), neg: side1_r.neg};
    end
  end

  // ---- stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en_w) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_w) begin
      abs_r   <= dot_r[DOT_W-1] ? MAG_W'(-dot_r) : MAG_W'(dot_r);
      mag3_r  <= mag2_r;
      side3_r <= '{ux: side2_r.ux, uy: side2_r.uy, nx: side2_r.nx, ny: side2_r.ny,
                   zero: side2_r.zero, neg: dot_r[DOT_W-1]};
    end
  end

  // ---- divider
  vrf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en_w),
    .in_valid  (v3_r),
    .in_num    ({abs_r, {FRAC_SH{1'b0}}}),
    .in_den    (mag3_r),
    .in_side   (side3_r),
    .out_valid (vd_w),
    .out_quo   (quo_w),
    .out_side  (sided_w)
  );

  // ---- stage 4: truncation toward zero, then sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en_w) begin
      v4_r <= vd_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en_w) begin
      q_r     <= sided_w.neg ? -$signed(quo_w) : $signed(quo_w);
      side4_r <= sided_w;
    end
  end

  // ---- stage 5: q*n, exact within the kept bits
  assign full_x_w = q_r * side4_r.nx;
  assign full_y_w = q_r * side4_r.ny;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en_w) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_w) begin
      px_r    <= full_x_w[QUO_W-1:0];
      py_r    <= full_y_w[QUO_W-1:0];
      side5_r <= side4_r;
    end
  end

  // ---- result: arithmetic shift, subtract, clip
  assign sx_w  = SUM_W'(px_r >>> Q_SH);
  assign sy_w  = SUM_W'(py_r >>> Q_SH);
  assign dx_w  = SUM_W'(side5_r.ux) - sx_w;
  assign dy_w  = SUM_W'(side5_r.uy) - sy_w;
  assign ovx_w = (dx_w[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){dx_w[SUM_W-1]}});
  assign ovy_w = (dy_w[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){dy_w[SUM_W-1]}});

  always_comb begin
    if (side5_r.zero) begin
      res_w.rx          = side5_r.ux;
      res_w.ry          = side5_r.uy;
      res_w.saturated   = 1'b0;
      res_w.zero_normal = 1'b1;
    end else begin
      res_w.rx          = ovx_w ? (dx_w[SUM_W-1] ? DATA_MIN : DATA_MAX) : dx_w[DATA_W-1:0];
      res_w.ry          = ovy_w ? (dy_w[SUM_W-1] ? DATA_MIN : DATA_MAX) : dy_w[DATA_W-1:0];
      res_w.saturated   = ovx_w || ovy_w;
      res_w.zero_normal = 1'b0;
    end
  end

  // ---- output FIFO
  assign push_w = en_w && v5_r;
  assign pop_w  = out_ch.valid && out_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_w && !pop_w) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_w && !push_w) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_w) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_w) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_w) begin
      mem_r[wr_ptr_r] <= res_w;
    end
  end

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.rx          = mem_r[rd_ptr_r].rx;
  assign out_ch.ry          = mem_r[rd_ptr_r].ry;
  assign out_ch.saturated   = mem_r[rd_ptr_r].saturated;
  assign out_ch.zero_normal = mem_r[rd_ptr_r].zero_normal;

  `VRF_ASSERT_NOW(a_zero_no_sat, out_ch.valid && out_ch.zero_normal, !out_ch.saturated, "zero normal beat flagged saturated")
  `VRF_ASSERT_NEXT(a_stall_holds, !en_w, $stable(v5_r) && $stable(px_r), "pipeline moved while stalled")
  `VRF_ASSERT_NEXT(a_cnt_up, push_w && !pop_w, cnt_r == $past(cnt_r) + 1'b1, "FIFO count missed a push")
  `VRF_ASSERT_NOW(a_push_room, push_w, cnt_r != CNT_W'(FIFO_DEPTH), "push into full FIFO")

endmodule
